/* hw/rtl/bcc_pkg.sv */
// Shared types and constants for the button click classifier.
// No dependencies; every other file uses this package by scoped names.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned CFG_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned IDX_W   = 2;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WINDOW   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SOURCE   = 2'd3;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd50;
    localparam logic [CFG_W-1:0] RST_LONG     = 16'd1500;
    localparam logic [CFG_W-1:0] RST_WINDOW   = 16'd400;
    localparam logic [CFG_W-1:0] RST_SOURCE   = 16'd0;

    // Classifier phases
    localparam logic [PHASE_W-1:0] PHASE_IDLE         = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_HELD         = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_SECOND  = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_RELEASE = 2'd3;

    // Alert levels
    localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_SINGLE = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_DOUBLE = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_LONG   = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_limit_ms;
        logic [CFG_W-1:0] long_press_limit_ms;
        logic [CFG_W-1:0] double_window_ms;
        logic [CFG_W-1:0] source_ident;
    } t_cfg;

    typedef struct packed {
        logic               emit;
        logic [LEVEL_W-1:0] level;
    } t_res;

endpackage

/* hw/rtl/bcc_in_if.sv */
// Input channel of the button click classifier: one button sample per transfer.
// Depends on bcc_pkg for field widths.
`timescale 1ns / 1ps

interface bcc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           pressed;
    logic [bcc_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, output pressed, output now_ms, input ready);
    modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

/* hw/rtl/bcc_out_if.sv */
// Output channel of the button click classifier: one alert per transfer.
// Depends on bcc_pkg for field widths.
`timescale 1ns / 1ps

interface bcc_out_if;
    logic                           valid;
    logic                           ready;
    logic [bcc_pkg::LEVEL_W-1:0]    alert_level;
    logic [bcc_pkg::CFG_W-1:0]      alert_source;

    modport source (output valid, output alert_level, output alert_source, input ready);
    modport sink   (input valid, input alert_level, input alert_source, output ready);
endinterface

/* hw/rtl/bcc_cfg.sv */
// Configuration register file: three 16-bit limits and the 16-bit source identifier.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bcc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bcc_pkg::CFG_W-1:0]   i_cfg_data,
    output bcc_pkg::t_cfg               o_cfg
);

    bcc_pkg::t_cfg r_cfg;
    bcc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bcc_pkg::CFG_DEBOUNCE: n_cfg.debounce_limit_ms   = i_cfg_data;
                bcc_pkg::CFG_LONG:     n_cfg.long_press_limit_ms = i_cfg_data;
                bcc_pkg::CFG_WINDOW:   n_cfg.double_window_ms    = i_cfg_data;
                bcc_pkg::CFG_SOURCE:   n_cfg.source_ident        = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit_ms   <= bcc_pkg::RST_DEBOUNCE;
            r_cfg.long_press_limit_ms <= bcc_pkg::RST_LONG;
            r_cfg.double_window_ms    <= bcc_pkg::RST_WINDOW;
            r_cfg.source_ident        <= bcc_pkg::RST_SOURCE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/bcc_core.sv */
// Phase machine of the classifier: phase and phase start time, duration compares.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_pressed,
    input  logic [bcc_pkg::TIME_W-1:0]  i_now_ms,
    input  bcc_pkg::t_cfg               i_cfg,
    output bcc_pkg::t_res               o_res
);

    logic [bcc_pkg::PHASE_W-1:0] r_phase;
    logic [bcc_pkg::PHASE_W-1:0] n_phase;
    logic [bcc_pkg::TIME_W-1:0]  r_start;
    logic [bcc_pkg::TIME_W-1:0]  n_start;
    logic [bcc_pkg::TIME_W-1:0]  elapsed;
    logic [bcc_pkg::TIME_W-1:0]  deb_ext;
    logic [bcc_pkg::TIME_W-1:0]  long_ext;
    logic [bcc_pkg::TIME_W-1:0]  win_ext;
    bcc_pkg::t_res               res;

    // Wrapping difference: a clock that steps back reads as a very long time
    assign elapsed  = i_now_ms - r_start;
    assign deb_ext  = {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, i_cfg.debounce_limit_ms};
    assign long_ext = {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, i_cfg.long_press_limit_ms};
    assign win_ext  = {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, i_cfg.double_window_ms};

    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        res.emit  = 1'b0;
        res.level = bcc_pkg::LEVEL_NONE;
        case (r_phase)
            bcc_pkg::PHASE_IDLE: begin
                if (i_pressed) begin
                    n_phase = bcc_pkg::PHASE_HELD;
                    n_start = i_now_ms;
                end
            end
            bcc_pkg::PHASE_HELD: begin
                if (!i_pressed) begin
                    // Debounce test goes first, even if it overlaps the long limit
                    if (elapsed < deb_ext) begin
                        n_phase = bcc_pkg::PHASE_IDLE;
                    end else if (elapsed > long_ext) begin
                        res.emit  = 1'b1;
                        res.level = bcc_pkg::LEVEL_LONG;
                        n_phase   = bcc_pkg::PHASE_IDLE;
                    end else begin
                        n_phase = bcc_pkg::PHASE_WAIT_SECOND;
                        n_start = i_now_ms;
                    end
                end
            end
            bcc_pkg::PHASE_WAIT_SECOND: begin
                // The window closes only on a released sample
                if (i_pressed) begin
                    res.emit  = 1'b1;
                    res.level = bcc_pkg::LEVEL_DOUBLE;
                    n_phase   = bcc_pkg::PHASE_WAIT_RELEASE;
                end else if (elapsed > win_ext) begin
                    res.emit  = 1'b1;
                    res.level = bcc_pkg::LEVEL_SINGLE;
                    n_phase   = bcc_pkg::PHASE_IDLE;
                end
            end
            default: begin
                if (!i_pressed) begin
                    n_phase = bcc_pkg::PHASE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bcc_pkg::PHASE_IDLE;
            r_start <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_start <= n_start;
        end
    end

    assign o_res = res;

endmodule

/* hw/rtl/bcc_oreg.sv */
// Alert output register: holds one alert until the receiver takes it.
// Depends on bcc_pkg and bcc_out_if.
`timescale 1ns / 1ps

module bcc_oreg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [bcc_pkg::LEVEL_W-1:0] i_level,
    input  logic [bcc_pkg::CFG_W-1:0]   i_source,
    output logic                        o_can_load,
    bcc_out_if.source                   o_out
);

    logic                        r_valid;
    logic [bcc_pkg::LEVEL_W-1:0] r_level;
    logic [bcc_pkg::CFG_W-1:0]   r_source;

    // A new alert may replace the held one in the cycle it is transferred
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_level  <= i_level;
            r_source <= i_source;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.alert_level  = r_level;
    assign o_out.alert_source = r_source;

endmodule

/* hw/rtl/button_click_classifier_unit.sv */
// Top level of the button click classifier: input register, phase machine,
// configuration registers and alert output register. Depends on bcc_pkg,
// bcc_in_if, bcc_out_if, bcc_cfg, bcc_core and bcc_oreg.
//
// Usage:
//   i_in carries one button sample (pressed, now_ms) per transfer; o_out
//   carries one alert (alert_level, alert_source) per transfer. A sample
//   gives zero or one alert. Registers are written through i_cfg_we,
//   i_cfg_idx and i_cfg_data; the user must write them only while no
//   sample is in flight, which the block itself does not enforce.
//   Path: a sample is registered in the input register at its transfer and
//   classified there; its alert is then registered in bcc_oreg onto o_out.
//   Throughput: one sample per cycle while no alert holds it; the phase update
//   is one 32-bit subtract from the stored start time and compares to limits.
//   Stall: while an alert waits on o_out, samples that raise no alert keep
//   flowing; a sample that would raise a second alert holds in the input
//   register, and i_in.ready drops until the waiting alert is transferred.
//   Reset (i_rst_n low, synchronous): phase goes idle, start time zero,
//   limits return to 50/1500/400 ms and source to zero, both stages empty.
`timescale 1ns / 1ps

module button_click_classifier_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bcc_in_if.sink                      i_in,
    bcc_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [bcc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bcc_pkg::CFG_W-1:0]   i_cfg_data
);

    logic                        r_in_valid;
    logic                        r_pressed;
    logic [bcc_pkg::TIME_W-1:0]  r_now_ms;
    logic                        adv;
    logic                        can_load;
    bcc_pkg::t_cfg               cfg;
    bcc_pkg::t_res               res;

    bcc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bcc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_pressed (r_pressed),
        .i_now_ms  (r_now_ms),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    bcc_oreg u_oreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv && res.emit),
        .i_level    (res.level),
        .i_source   (cfg.source_ident),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // Advance the held sample unless its alert has nowhere to go
    assign adv        = r_in_valid && (!res.emit || can_load);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_pressed <= i_in.pressed;
            r_now_ms  <= i_in.now_ms;
        end
    end

endmodule

/* hw/rtl/bcc_checker.sv */
// Port-level checks of the button click classifier, bound to the top level.
// Depends on bcc_pkg and button_click_classifier_unit.
`timescale 1ns / 1ps

module bcc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [bcc_pkg::LEVEL_W-1:0] i_out_level,
    input  logic [bcc_pkg::CFG_W-1:0]   i_out_source
);

    // An alert held on the output stays valid until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("alert dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_level) && $stable(i_out_source)))
        else $error("alert payload changed while stalled");

    // Every alert carries a real level
    a_level_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_level != bcc_pkg::LEVEL_NONE))
        else $error("alert with level zero");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("alert valid after reset");

    // While the output stays free, nothing can hold back a sample
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && $past(!i_out_valid) && $past(i_rst_n)) |-> i_in_ready)
        else $error("input blocked with empty output");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_level  (o_out.alert_level),
    .i_out_source (o_out.alert_source)
);
